>>> rtl/core/vbs_pkg.sv
// ----------------------------------------------------------------------------
// vbs_pkg: shared types for the vertex bone skinning core
// Command codes, register indexes, payload words and the link between cells.
// ----------------------------------------------------------------------------
package vbs_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_WEIGHT = 2'd1,
    CMD_XFORM  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [3:0] CFG_ENABLE = 4'd0;
  localparam logic [3:0] CFG_COUNT  = 4'd1;

  localparam int ELEMS_PER_BONE = 12;
  localparam int WGT_SHIFT      = 15;
  localparam logic [15:0] WGT_ONE = 16'd32768;

  typedef struct packed {
    logic [1:0]         command;
    logic [2:0]         bone_index;
    logic [3:0]         element_index;
    logic signed [31:0] value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } skin_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } skin_out_t;

  // store write bus, broadcast to every cell
  typedef struct packed {
    logic               mat_we;
    logic               wgt_we;
    logic [2:0]         bone;
    logic [3:0]         elem;
    logic signed [31:0] data;
    logic [15:0]        weight;
  } skin_wr_t;

  // vertex handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } skin_link_t;

endpackage

>>> rtl/core/vbs_cell.sv
// ----------------------------------------------------------------------------
// vbs_cell: one bone of the skinning chain
// Holds one bone matrix and weight; adds this bone's weighted term to the sum.
// ----------------------------------------------------------------------------
module vbs_cell #(
  parameter int FRAC_BITS = 16,
  parameter int BONE_ID   = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vbs_pkg::skin_wr_t     wr_i,
  input  logic [3:0]            bone_cnt_i,
  input  vbs_pkg::skin_link_t   link_i,
  input  logic signed [70-FRAC_BITS:0] acc_i [3],
  output vbs_pkg::skin_link_t   link_o,
  output logic signed [70-FRAC_BITS:0] acc_o [3]
);
  import vbs_pkg::*;

  localparam int T_W   = 66 - FRAC_BITS;
  localparam int W_W   = T_W + 17;
  localparam int ACC_W = T_W + 5;
  localparam logic [3:0] MY_ID = 4'(BONE_ID);

  typedef enum logic [2:0] {S_IDLE, S_MAC, S_WGT, S_WFIN, S_OUT} state_t;

  state_t             state_r;
  logic [3:0]         cnt_r;
  logic [1:0]         row_r, col_r, wcnt_r;
  logic signed [31:0] mat_r [ELEMS_PER_BONE];
  logic [15:0]        wgt_r;
  logic signed [31:0] pos_r [3];
  logic signed [T_W-1:0]   t_r [3];
  logic signed [ACC_W-1:0] acc_r [3];
  logic signed [63:0]      prod_r;
  logic signed [31:0]      mval_r;
  logic [1:0]              mrow_r, wrow_r;
  logic                    mtr_r, pv_r, wv_r;
  logic signed [W_W-1:0]   wprod_r;
  logic                    active;

  assign active = (MY_ID < bone_cnt_i) && (wgt_r != '0);

  // store writes
  always_ff @(posedge clk) begin
    if (wr_i.mat_we && wr_i.bone == MY_ID[2:0] && wr_i.elem < 4'(ELEMS_PER_BONE)) begin
      mat_r[wr_i.elem] <= wr_i.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wgt_r <= '0;
    end else if (wr_i.wgt_we && wr_i.bone == MY_ID[2:0]) begin
      wgt_r <= wr_i.weight;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pv_r    <= 1'b0;
      wv_r    <= 1'b0;
      cnt_r   <= '0;
      row_r   <= '0;
      col_r   <= '0;
      wcnt_r  <= '0;
    end else begin
      pv_r <= 1'b0;
      wv_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          cnt_r  <= '0;
          row_r  <= '0;
          col_r  <= '0;
          wcnt_r <= '0;
          if (link_i.valid) begin
            state_r <= active ? S_MAC : S_OUT;
          end
        end
        S_MAC: begin
          pv_r  <= 1'b1;
          cnt_r <= cnt_r + 4'd1;
          if (row_r == 2'd2) begin
            row_r <= '0;
            col_r <= col_r + 2'd1;
          end else begin
            row_r <= row_r + 2'd1;
          end
          if (cnt_r == 4'(ELEMS_PER_BONE - 1)) begin
            state_r <= S_WGT;
          end
        end
        S_WGT: begin
          wv_r   <= 1'b1;
          wcnt_r <= wcnt_r + 2'd1;
          if (wcnt_r == 2'd2) begin
            state_r <= S_WFIN;
          end
        end
        S_WFIN: state_r <= S_OUT;
        S_OUT:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && link_i.valid) begin
      pos_r[0] <= link_i.px;
      pos_r[1] <= link_i.py;
      pos_r[2] <= link_i.pz;
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= acc_i[i];
        t_r[i]   <= '0;
      end
    end
    if (state_r == S_MAC) begin
      prod_r <= (col_r == 2'd3) ? 64'sd0 : pos_r[col_r] * mat_r[cnt_r];
      mval_r <= mat_r[cnt_r];
      mrow_r <= row_r;
      mtr_r  <= (col_r == 2'd3);
    end
    if (pv_r) begin
      t_r[mrow_r] <= t_r[mrow_r] + (mtr_r ? T_W'(mval_r) : T_W'(prod_r >>> FRAC_BITS));
    end
    if (state_r == S_WGT) begin
      wprod_r <= W_W'(t_r[wcnt_r]) * W_W'($signed({1'b0, wgt_r}));
      wrow_r  <= wcnt_r;
    end
    if (wv_r) begin
      acc_r[wrow_r] <= acc_r[wrow_r] + ACC_W'(wprod_r >>> WGT_SHIFT);
    end
  end

  assign link_o.valid = (state_r == S_OUT);
  assign link_o.px    = pos_r[0];
  assign link_o.py    = pos_r[1];
  assign link_o.pz    = pos_r[2];
  assign acc_o        = acc_r;

endmodule

>>> rtl/core/vertex_bone_skinning_core.sv
// ----------------------------------------------------------------------------
// vertex_bone_skinning_core: linear blend skinning of vertex positions
// Loads bone matrices and weights, and blends vertex positions over bones.
// ----------------------------------------------------------------------------
// A word accepted with start high while busy is low either loads one matrix
// element, sets one bone weight (clamped to 0..1.0) or transforms a vertex.
// Loads and weight writes take effect at the accepting edge and give no
// result. With skinning disabled a transform returns its position on the
// next cycle and busy stays low. With skinning enabled the vertex walks a
// chain of one cell per bone; a cell whose bone is in use (index below the
// clamped weight_count, nonzero weight) takes its 12 matrix elements in turn
// through its multiplier, then 3 weight multiplies, pipeline drain and
// handoff; an unused one only hands the vertex on. busy stays high until
// the result strobe. out_valid is high for exactly one cycle and the
// receiver must take the word then; there is no backpressure. A new word
// may be accepted in the strobe cycle. Matrix entries are not reset and
// must be written before use; weights reset to zero.
module vertex_bone_skinning_core #(
  parameter int NUM_BONES = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  vbs_pkg::skin_in_t in_word,
  output logic              out_valid,
  output vbs_pkg::skin_out_t out_word,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_idx,
  input  logic [3:0]        cfg_data
);
  import vbs_pkg::*;

  localparam int T_W   = 66 - FRAC_BITS;
  localparam int ACC_W = T_W + 5;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'($signed(32'h8000_0000));

  logic        en_r;
  logic [3:0]  wcnt_r;
  logic [3:0]  bone_cnt;
  logic        busy_r, out_valid_r, accept;
  skin_out_t   out_r;
  skin_link_t  launch_r;
  skin_wr_t    wr;
  skin_link_t  link [NUM_BONES+1];
  logic signed [ACC_W-1:0] acc [NUM_BONES+1][3];
  logic [15:0] wclamp;

  assign accept = start && !busy_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      wcnt_r <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ENABLE: en_r   <= cfg_data[0];
        CFG_COUNT:  wcnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp weight_count into 1..NUM_BONES
  always_comb begin
    if (wcnt_r == '0) begin
      bone_cnt = 4'd1;
    end else if (wcnt_r > 4'(NUM_BONES)) begin
      bone_cnt = 4'(NUM_BONES);
    end else begin
      bone_cnt = wcnt_r;
    end
  end

  // clamp weight into 0..1.0
  always_comb begin
    if (in_word.value < 0) begin
      wclamp = '0;
    end else if (in_word.value > $signed({16'd0, WGT_ONE})) begin
      wclamp = WGT_ONE;
    end else begin
      wclamp = in_word.value[15:0];
    end
  end

  assign wr.mat_we = accept && in_word.command == CMD_LOAD;
  assign wr.wgt_we = accept && in_word.command == CMD_WEIGHT;
  assign wr.bone   = in_word.bone_index;
  assign wr.elem   = in_word.element_index;
  assign wr.data   = in_word.value;
  assign wr.weight = wclamp;

  // head of the chain: vertex enters with a zero sum
  assign link[0] = launch_r;
  assign acc[0][0] = '0;
  assign acc[0][1] = '0;
  assign acc[0][2] = '0;

  for (genvar g = 0; g < NUM_BONES; g++) begin : g_cell
    vbs_cell #(
      .FRAC_BITS (FRAC_BITS),
      .BONE_ID   (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .wr_i       (wr),
      .bone_cnt_i (bone_cnt),
      .link_i     (link[g]),
      .acc_i      (acc[g]),
      .link_o     (link[g+1]),
      .acc_o      (acc[g+1])
    );
  end

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > SAT_MAX) begin
      return 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      return $signed(32'h8000_0000);
    end
    return v[31:0];
  endfunction

  // launch, pass-through and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      launch_r.valid <= 1'b0;
    end else begin
      out_valid_r    <= 1'b0;
      launch_r.valid <= 1'b0;
      if (accept && in_word.command == CMD_XFORM) begin
        if (en_r) begin
          launch_r.valid <= 1'b1;
          busy_r         <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end
      if (link[NUM_BONES].valid) begin
        out_valid_r <= 1'b1;
        busy_r      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      launch_r.px <= in_word.pos_x;
      launch_r.py <= in_word.pos_y;
      launch_r.pz <= in_word.pos_z;
    end
    if (accept && in_word.command == CMD_XFORM && !en_r) begin
      out_r.out_x <= in_word.pos_x;
      out_r.out_y <= in_word.pos_y;
      out_r.out_z <= in_word.pos_z;
    end else if (link[NUM_BONES].valid) begin
      out_r.out_x <= sat32(acc[NUM_BONES][0]);
      out_r.out_y <= sat32(acc[NUM_BONES][1]);
      out_r.out_z <= sat32(acc[NUM_BONES][2]);
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

`ifndef SYNTHESIS
  a_launch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    launch_r.valid |-> busy_r) else $error("launch without busy");
  a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
    link[NUM_BONES].valid |-> busy_r) else $error("chain result while idle");
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> out_valid_r) else $error("busy dropped without result");
`endif

endmodule
